@@ hw/rtl/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants for the circular deque
// ----------------------------------------------------------------------------
package cdq_pkg;

  // default geometry
  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned WORD_BITS_DEF = 32;

  // fixed width of the push and pop value ports
  localparam int unsigned VALUE_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // per-cycle command to one chain of cells
  typedef struct packed {
    logic ins_front;  // shift toward the far end, new word enters cell 0
    logic del_front;  // shift toward cell 0, cell 0 word leaves
    logic load_at;    // cell whose index equals the count takes the new word
  } chain_ctl_t;

endpackage

@@ hw/rtl/cdq_cell.sv @@
// ----------------------------------------------------------------------------
// cdq_cell
// one storage cell of a deque chain
// ----------------------------------------------------------------------------
module cdq_cell #(
  parameter int unsigned WORD_BITS = cdq_pkg::WORD_BITS_DEF,
  parameter int unsigned CNT_W     = 6,
  parameter int unsigned IDX       = 0
) (
  input  logic                     clk_i,
  input  cdq_pkg::chain_ctl_t      ctl_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic [WORD_BITS-1:0]     word_i,
  input  logic [WORD_BITS-1:0]     prev_i,
  input  logic [WORD_BITS-1:0]     next_i,
  output logic [WORD_BITS-1:0]     data_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [WORD_BITS-1:0] data_d, data_q;
  logic                 at_count;

  assign at_count = (count_i == MyIdx);

  always_comb begin
    data_d = data_q;
    priority if (ctl_i.ins_front) begin
      data_d = prev_i;
    end else if (ctl_i.del_front) begin
      data_d = next_i;
    end else if (ctl_i.load_at && at_count) begin
      data_d = word_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ hw/rtl/cdq_chain.sv @@
// ----------------------------------------------------------------------------
// cdq_chain
// row of cells holding all entries in order from one end of the deque
// ----------------------------------------------------------------------------
module cdq_chain #(
  parameter int unsigned NCELLS    = 63,
  parameter int unsigned WORD_BITS = cdq_pkg::WORD_BITS_DEF,
  parameter int unsigned CNT_W     = 6
) (
  input  logic                     clk_i,
  input  cdq_pkg::chain_ctl_t      ctl_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic [WORD_BITS-1:0]     word_i,
  output logic [WORD_BITS-1:0]     head_o
);

  logic [WORD_BITS-1:0] data [NCELLS];

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    logic [WORD_BITS-1:0] prev_w, next_w;

    if (i == 0) begin : g_first
      assign prev_w = word_i;
    end else begin : g_mid
      assign prev_w = data[i-1];
    end

    if (i == NCELLS - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = data[i+1];
    end

    cdq_cell #(
      .WORD_BITS (WORD_BITS),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .count_i (count_i),
      .word_i  (word_i),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .data_o  (data[i])
    );
  end

  assign head_o = data[0];

endmodule

@@ hw/rtl/circular_deque.sv @@
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue of up to DEPTH-1 words built from two chains of cells
// ----------------------------------------------------------------------------
// the result is registered and valid in the cycle after the request is taken
// throughput: one request per cycle; every operation is at most a single shift
//   or load in each chain, limited only by the output register handshake
// reset: entry count and output valid clear at once; cell contents are not
//   cleared since an entry is only read after it was written
module circular_deque #(
  parameter int unsigned DEPTH     = cdq_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = cdq_pkg::WORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         operation_i,
  input  logic signed [cdq_pkg::VALUE_W-1:0] push_value_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [cdq_pkg::VALUE_W-1:0] pop_value_o,
  output logic [1:0]                         status_o,
  output logic                               now_empty_o,
  output logic                               now_full_o
);

  localparam int unsigned VW     = cdq_pkg::VALUE_W;
  localparam int unsigned NCELLS = DEPTH - 1;
  localparam int unsigned CNT_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(DEPTH - 1);

  // the front chain keeps the front entry in cell 0, the rear chain keeps
  // the rear entry in cell 0; both hold every entry, so each end is always
  // at a fixed cell and the far end of each chain is found by the count

  logic [CNT_W-1:0]     count_d, count_q;
  logic                 accept;
  logic                 is_empty, is_full;
  cdq_pkg::op_e         op;
  cdq_pkg::chain_ctl_t  front_ctl, rear_ctl;
  logic [WORD_BITS-1:0] store_word;
  logic [WORD_BITS-1:0] front_head, rear_head;
  logic [VW-1:0]        front_val, rear_val;

  logic                 out_valid_q;
  logic [VW-1:0]        pop_d, pop_q;
  cdq_pkg::status_e     status_d, status_q;
  logic                 empty_q, full_q;

  assign op       = cdq_pkg::op_e'(operation_i);
  assign accept   = in_valid_i && in_ready_o;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntMax);

  // output register frees as soon as its result is taken
  assign in_ready_o = !out_valid_q || out_ready_i;

  // word as stored: low WORD_BITS of the sign-extended push value
  if (WORD_BITS <= VW) begin : g_store_cut
    assign store_word = push_value_i[WORD_BITS-1:0];
  end else begin : g_store_ext
    assign store_word = {{(WORD_BITS-VW){push_value_i[VW-1]}}, push_value_i};
  end

  // popped word sign-extended from WORD_BITS, then cut to the port width
  if (WORD_BITS >= VW) begin : g_pop_cut
    assign front_val = front_head[VW-1:0];
    assign rear_val  = rear_head[VW-1:0];
  end else begin : g_pop_ext
    assign front_val = {{(VW-WORD_BITS){front_head[WORD_BITS-1]}}, front_head};
    assign rear_val  = {{(VW-WORD_BITS){rear_head[WORD_BITS-1]}}, rear_head};
  end

  // decode the request into chain commands, next count and result
  always_comb begin
    front_ctl = '0;
    rear_ctl  = '0;
    count_d   = count_q;
    pop_d     = '0;
    status_d  = cdq_pkg::ST_DONE;
    if (accept) begin
      unique case (op)
        cdq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            status_d = cdq_pkg::ST_OVERFLOW;
          end else begin
            // new front enters cell 0 of the front chain, far end of the rear
            front_ctl.ins_front = 1'b1;
            rear_ctl.load_at    = 1'b1;
            count_d             = count_q + CNT_W'(1);
          end
        end
        cdq_pkg::OP_PUSH_REAR: begin
          if (is_full) begin
            status_d = cdq_pkg::ST_OVERFLOW;
          end else begin
            rear_ctl.ins_front = 1'b1;
            front_ctl.load_at  = 1'b1;
            count_d            = count_q + CNT_W'(1);
          end
        end
        cdq_pkg::OP_POP_FRONT: begin
          if (is_empty) begin
            status_d = cdq_pkg::ST_UNDERFLOW;
          end else begin
            // rear chain just loses its far entry through the count
            front_ctl.del_front = 1'b1;
            pop_d               = front_val;
            count_d             = count_q - CNT_W'(1);
          end
        end
        cdq_pkg::OP_POP_REAR: begin
          if (is_empty) begin
            status_d = cdq_pkg::ST_UNDERFLOW;
          end else begin
            rear_ctl.del_front = 1'b1;
            pop_d              = rear_val;
            count_d            = count_q - CNT_W'(1);
          end
        end
        default: begin
          status_d = cdq_pkg::ST_DONE;
        end
      endcase
    end
  end

  cdq_chain #(
    .NCELLS    (NCELLS),
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W)
  ) u_front_chain (
    .clk_i   (clk_i),
    .ctl_i   (front_ctl),
    .count_i (count_q),
    .word_i  (store_word),
    .head_o  (front_head)
  );

  cdq_chain #(
    .NCELLS    (NCELLS),
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W)
  ) u_rear_chain (
    .clk_i   (clk_i),
    .ctl_i   (rear_ctl),
    .count_i (count_q),
    .word_i  (store_word),
    .head_o  (rear_head)
  );

  // entry count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded on each accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_q    <= pop_d;
      status_q <= status_d;
      empty_q  <= (count_d == '0);
      full_q   <= (count_d == CntMax);
    end
  end

  assign out_valid_o = out_valid_q;
  assign pop_value_o = pop_q;
  assign status_o    = status_q;
  assign now_empty_o = empty_q;
  assign now_full_o  = full_q;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------

  // count never runs past capacity
  a_count_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni) count_q <= CntMax
  ) else $error("entry count above capacity");

  // a rejected push only happens on a full deque, which stays full
  a_overflow_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == cdq_pkg::ST_OVERFLOW) |-> now_full_o
  ) else $error("overflow reported while not full");

  // a rejected pop only happens on an empty deque, which stays empty
  a_underflow_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == cdq_pkg::ST_UNDERFLOW) |-> now_empty_o
  ) else $error("underflow reported while not empty");

  // rejected requests return no word
  a_reject_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != cdq_pkg::ST_DONE) |-> (pop_value_o == '0)
  ) else $error("rejected request returned a word");

endmodule

@@ test/tb_circular_deque.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque
// self-checking bench for the circular deque: pushes and pops at both ends,
// underflow and overflow rejects, a full fill and drain under a long result
// hold-off, then biased random traffic checked against a local deque copy
// ----------------------------------------------------------------------------
module tb_circular_deque;

  localparam int unsigned DEPTH     = cdq_pkg::DEPTH_DEF;
  localparam int unsigned WORD_BITS = cdq_pkg::WORD_BITS_DEF;
  localparam int unsigned VALUE_W   = cdq_pkg::VALUE_W;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned MAX_GAP   = 19;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned SETTLE    = 10;       // result register plus margin
  localparam int unsigned CYCLE_CAP = 200000;

  // one result as the block should report it
  typedef struct {
    logic signed [VALUE_W-1:0] pop_value;
    cdq_pkg::status_e          status;
    logic                      now_empty;
    logic                      now_full;
  } deque_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                operation;
  logic signed [VALUE_W-1:0] push_value;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VALUE_W-1:0] pop_value;
  logic [1:0]                status;
  logic                      now_empty;
  logic                      now_full;

  // local copy of the deque contents and pointers
  logic [VALUE_W-1:0] slot_words [DEPTH];
  logic [IDX_W-1:0]   front_idx;
  logic [IDX_W-1:0]   back_idx;

  deque_result_t outcome_fifo [$];
  deque_result_t oldest_outcome;
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  bit            gaps_on;       // random idle cycles on both sides
  int unsigned   hold_cycles;   // one-shot long stall request for the receiver

  circular_deque #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .operation_i (operation),
    .push_value_i(push_value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pop_value_o (pop_value),
    .status_o    (status),
    .now_empty_o (now_empty),
    .now_full_o  (now_full)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ------------------------------------------------------------------------
  // local deque
  // ------------------------------------------------------------------------

  function automatic logic [IDX_W-1:0] idx_up(logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_down(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic bit deque_is_full();
    return idx_up(back_idx) == front_idx;
  endfunction

  // keep WORD_BITS of the word and sign-extend it back to the port width
  function automatic logic signed [VALUE_W-1:0] fit_word(logic [VALUE_W-1:0] w);
    logic signed [VALUE_W-1:0] t;
    t = w << (VALUE_W - WORD_BITS);
    return t >>> (VALUE_W - WORD_BITS);
  endfunction

  // applies one operation to the local deque and returns what the block owes
  function automatic deque_result_t apply_deque_op(cdq_pkg::op_e op,
                                                   logic signed [VALUE_W-1:0] value);
    deque_result_t r;
    r.pop_value = '0;
    r.status    = cdq_pkg::ST_DONE;
    case (op)
      cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
        if (deque_is_full()) begin
          r.status = cdq_pkg::ST_OVERFLOW;
        end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
          front_idx             = idx_down(front_idx);
          slot_words[front_idx] = fit_word(value);
        end else begin
          slot_words[back_idx] = fit_word(value);
          back_idx             = idx_up(back_idx);
        end
      end
      default: begin
        if (front_idx == back_idx) begin
          r.status = cdq_pkg::ST_UNDERFLOW;
        end else if (op == cdq_pkg::OP_POP_FRONT) begin
          r.pop_value = fit_word(slot_words[front_idx]);
          front_idx   = idx_up(front_idx);
        end else begin
          back_idx    = idx_down(back_idx);
          r.pop_value = fit_word(slot_words[back_idx]);
        end
      end
    endcase
    r.now_empty = (front_idx == back_idx);
    r.now_full  = deque_is_full();
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------------

  // offers one request and records its outcome at the accepting edge;
  // valid is only lowered when a gap follows, so back-to-back requests
  // never see a low and a high in the same step
  task automatic send_request(cdq_pkg::op_e op, logic signed [VALUE_W-1:0] value);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    push_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    outcome_fifo.push_back(apply_deque_op(op, value));
  endtask

  task automatic send_push(cdq_pkg::op_e op);
    send_request(op, $urandom());
  endtask

  // sender goes quiet until every outstanding result is back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outcome_fifo.size() != 0) @(posedge clk);
  endtask

  function automatic cdq_pkg::op_e any_push();
    return $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT;
  endfunction

  function automatic cdq_pkg::op_e any_pop();
    return $urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT;
  endfunction

  // ------------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------------

  // receiver: random stall before each result, or one long hold when asked
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare every accepted result with the oldest outstanding outcome
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (outcome_fifo.size() == 0) begin
        $error("result with no request outstanding: pop_value %0d status %0d",
               pop_value, status);
        mismatch_count++;
      end else begin
        oldest_outcome = outcome_fifo.pop_front();
        if (pop_value !== oldest_outcome.pop_value) begin
          $error("pop_value: expected %0d, got %0d", oldest_outcome.pop_value, pop_value);
          mismatch_count++;
        end
        if (status !== oldest_outcome.status) begin
          $error("status: expected %0d, got %0d", oldest_outcome.status, status);
          mismatch_count++;
        end
        if (now_empty !== oldest_outcome.now_empty) begin
          $error("now_empty: expected %0d, got %0d", oldest_outcome.now_empty, now_empty);
          mismatch_count++;
        end
        if (now_full !== oldest_outcome.now_full) begin
          $error("now_full: expected %0d, got %0d", oldest_outcome.now_full, now_full);
          mismatch_count++;
        end
      end
    end
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // pops at both ends of a fresh deque are rejected
  task automatic test_empty_pops();
    send_request(cdq_pkg::OP_POP_FRONT, $urandom());
    send_request(cdq_pkg::OP_POP_REAR, $urandom());
  endtask

  // extreme words through both ends, front push wraps the index below zero
  task automatic test_push_pop_extremes();
    send_request(cdq_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff);
    send_request(cdq_pkg::OP_PUSH_REAR, 32'sh8000_0000);
    send_request(cdq_pkg::OP_PUSH_FRONT, 32'sh0000_0000);
    send_request(cdq_pkg::OP_PUSH_REAR, 32'shffff_ffff);
    send_request(cdq_pkg::OP_PUSH_FRONT, 32'sh5555_5555);
    send_request(cdq_pkg::OP_PUSH_REAR, 32'shaaaa_aaaa);
    send_request(cdq_pkg::OP_POP_FRONT, $urandom());
    send_request(cdq_pkg::OP_POP_REAR, $urandom());
    send_request(cdq_pkg::OP_POP_FRONT, $urandom());
    send_request(cdq_pkg::OP_POP_REAR, $urandom());
    // stack behavior at the front, queue behavior front to rear
    send_request(cdq_pkg::OP_PUSH_FRONT, 32'sh0000_0001);
    send_request(cdq_pkg::OP_POP_FRONT, $urandom());
    send_request(cdq_pkg::OP_PUSH_REAR, 32'sh1234_5678);
    send_request(cdq_pkg::OP_POP_FRONT, $urandom());
    send_request(cdq_pkg::OP_POP_REAR, $urandom());
    send_request(cdq_pkg::OP_POP_FRONT, $urandom());
    // now empty again
    send_request(cdq_pkg::OP_POP_REAR, $urandom());
    send_request(cdq_pkg::OP_POP_FRONT, $urandom());
  endtask

  // fill to the brim with the receiver held off, push into a full deque at
  // both ends, then empty it and pop past the bottom at both ends
  task automatic test_fill_and_drain();
    wait_all_results();
    gaps_on     = 1'b0;
    hold_cycles = LONG_HOLD;
    while (!deque_is_full()) send_push(any_push());
    send_push(cdq_pkg::OP_PUSH_FRONT);
    send_push(cdq_pkg::OP_PUSH_REAR);
    gaps_on = 1'b1;
    while (front_idx != back_idx) send_request(any_pop(), $urandom());
    send_request(cdq_pkg::OP_POP_FRONT, $urandom());
    send_request(cdq_pkg::OP_POP_REAR, $urandom());
    wait_all_results();
  endtask

  // phases biased toward pushes, pops or neither so full and empty recur
  task automatic test_random_mix();
    int unsigned push_pct;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      gaps_on = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < 45; n++) begin
        if ($urandom_range(0, 99) < push_pct) send_push(any_push());
        else send_request(any_pop(), $urandom());
      end
      if (phase % 2 == 1) wait_all_results();
    end
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    operation      = cdq_pkg::OP_PUSH_FRONT;
    push_value     = '0;
    gaps_on        = 1'b1;
    hold_cycles    = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    front_idx      = '0;
    back_idx       = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pops();
    test_push_pop_extremes();
    test_fill_and_drain();
    test_random_mix();

    wait_all_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
